FILE: rtl/lurl_pkg.sv
// Package for the longest unique run length block.
// Holds the default parameter values and the fixed widths of the channel payloads.
// No dependencies.
package lurl_pkg;

    localparam int POSITION_BITS_DEFAULT = 16;
    localparam int SYMBOL_BITS_DEFAULT   = 8;

    localparam int SYMBOL_WIDTH = 8;
    localparam int LENGTH_WIDTH = 17;

    localparam logic [LENGTH_WIDTH-1:0] LENGTH_MAX = 17'h1FFFF;

    typedef logic [SYMBOL_WIDTH-1:0] symbol_t;
    typedef logic [LENGTH_WIDTH-1:0] length_t;

endpackage

FILE: rtl/lurl_if.sv
// Valid/ready channel interfaces of the longest unique run length block.
// Depends on lurl_pkg for the payload types.
interface lurl_in_if;
    logic              valid;
    logic              ready;
    lurl_pkg::symbol_t symbol;
    logic              last_symbol;

    modport source (output valid, output symbol, output last_symbol, input ready);
    modport sink (input valid, input symbol, input last_symbol, output ready);
endinterface

interface lurl_out_if;
    logic              valid;
    logic              ready;
    lurl_pkg::length_t longest_length;
    logic              overflow;

    modport source (output valid, output longest_length, output overflow, input ready);
    modport sink (input valid, input longest_length, input overflow, output ready);
endinterface

FILE: rtl/longest_unique_run_length_top.sv
// Top level of the longest unique run length block.
// Depends on lurl_pkg, the channel interfaces in lurl_if and the RAM lurl_pos_ram.
//
//   Channel   Direction   Payload                        Transfer when
//   in_ch     sink        symbol[7:0], last_symbol       valid && ready
//   out_ch    source      longest_length[16:0], overflow valid && ready
//
// Flow: one byte is taken every cycle unless the input is stalled as below. A byte
// waits in the lookup stage for the position RAM read issued at its transfer; its result,
// if it is the final byte, then goes into the output register.
// Reset: all control state and the seen bits clear at once; no clearing pass is run.
// Stalls: a held output only stops the input when a final byte reaches the lookup
// stage while the output register is still full.
//
// The block tracks a sliding window over the string. For every symbol value it keeps a
// seen bit in flip-flops and the position of its last occurrence in a RAM. When a
// symbol repeats inside the window, the window start moves just past the previous
// occurrence, and the best window length is updated. On the final byte the best length
// is sent out, clamped to the field width, together with the overflow flag, and the
// string state is cleared.
//
// The RAM read for a byte is issued at the byte's transfer. The byte in the lookup stage
// may write the same entry at that very edge, and the RAM then returns the older value,
// so that write is captured in a forwarding register and takes precedence in the
// lookup. No other write can fall between a read and its use, since only the lookup
// stage writes the RAM.
module longest_unique_run_length_top #(
    parameter int POSITION_BITS = lurl_pkg::POSITION_BITS_DEFAULT,
    parameter int SYMBOL_BITS   = lurl_pkg::SYMBOL_BITS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    lurl_in_if.sink           in_ch,
    lurl_out_if.source        out_ch
);

    localparam int NUM_SYMBOLS = 2 ** SYMBOL_BITS;
    localparam int COUNT_BITS  = POSITION_BITS + 1;
    // Width wide enough to compare the best length against the field limit.
    localparam int CLAMP_BITS  = (COUNT_BITS > lurl_pkg::LENGTH_WIDTH) ?
                                 COUNT_BITS : lurl_pkg::LENGTH_WIDTH;

    // Handshake terms.
    logic in_accept;
    logic out_free;
    logic stage_go;

    // Lookup stage.
    logic                     stage_valid_reg, stage_valid_next;
    logic [SYMBOL_BITS-1:0]   stage_sym_reg;
    logic                     stage_last_reg;
    logic                     fwd_hit_reg;
    logic [POSITION_BITS-1:0] fwd_pos_reg;
    logic [SYMBOL_BITS-1:0]   in_sym;

    // String state.
    logic [COUNT_BITS-1:0]    count_reg, count_next;
    logic [POSITION_BITS-1:0] win_start_reg, win_start_next;
    logic [COUNT_BITS-1:0]    best_reg, best_next;
    logic                     ovf_reg, ovf_next;
    logic [NUM_SYMBOLS-1:0]   seen_reg, seen_next;

    // Output register.
    logic                     out_valid_reg, out_valid_next;
    lurl_pkg::length_t        out_len_reg;
    logic                     out_ovf_reg;

    // Lookup datapath.
    logic [POSITION_BITS-1:0] ram_rd_data;
    logic [POSITION_BITS-1:0] cur_pos;
    logic [POSITION_BITS-1:0] prev_pos;
    logic [POSITION_BITS-1:0] moved_start;
    logic [COUNT_BITS-1:0]    run_len;
    logic [COUNT_BITS-1:0]    best_upd;
    logic [CLAMP_BITS-1:0]    best_wide;
    lurl_pkg::length_t        len_clamped;
    logic                     has_room;
    logic                     repeat_hit;
    logic                     ram_wr_en;

    assign in_sym    = in_ch.symbol[SYMBOL_BITS-1:0];
    assign in_accept = in_ch.valid && in_ch.ready;
    assign out_free  = !out_valid_reg || out_ch.ready;
    // Only a final byte needs room in the output register.
    assign stage_go  = stage_valid_reg && (!stage_last_reg || out_free);

    assign in_ch.ready = !stage_valid_reg || stage_go;

    lurl_pos_ram #(
        .ADDR_BITS (SYMBOL_BITS),
        .DATA_BITS (POSITION_BITS)
    ) u_pos_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (stage_sym_reg),
        .wr_data (cur_pos),
        .rd_en   (in_accept),
        .rd_addr (in_sym),
        .rd_data (ram_rd_data)
    );

    // Window update for the byte in the lookup stage.
    always_comb
    begin
        has_room    = !count_reg[POSITION_BITS];
        cur_pos     = count_reg[POSITION_BITS-1:0];
        prev_pos    = fwd_hit_reg ? fwd_pos_reg : ram_rd_data;
        repeat_hit  = seen_reg[stage_sym_reg] && (prev_pos >= win_start_reg);
        moved_start = repeat_hit ? (prev_pos + {{(POSITION_BITS-1){1'b0}}, 1'b1})
                                 : win_start_reg;
        run_len     = {1'b0, cur_pos} - {1'b0, moved_start} + {{POSITION_BITS{1'b0}}, 1'b1};
        best_upd    = (has_room && (run_len > best_reg)) ? run_len : best_reg;
        ram_wr_en   = stage_go && has_room;
        best_wide   = CLAMP_BITS'(best_upd);
        len_clamped = (best_wide > CLAMP_BITS'(lurl_pkg::LENGTH_MAX)) ?
                      lurl_pkg::LENGTH_MAX : best_wide[lurl_pkg::LENGTH_WIDTH-1:0];
    end

    // Next values of the string state.
    always_comb
    begin
        count_next     = count_reg;
        win_start_next = win_start_reg;
        best_next      = best_reg;
        ovf_next       = ovf_reg;
        seen_next      = seen_reg;
        if (stage_go)
        begin
            if (stage_last_reg)
            begin
                count_next     = '0;
                win_start_next = '0;
                best_next      = '0;
                ovf_next       = 1'b0;
                seen_next      = '0;
            end
            else if (has_room)
            begin
                count_next               = count_reg + {{POSITION_BITS{1'b0}}, 1'b1};
                win_start_next           = moved_start;
                best_next                = best_upd;
                seen_next[stage_sym_reg] = 1'b1;
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        if (in_accept)
        begin
            stage_valid_next = 1'b1;
        end
        else if (stage_go)
        begin
            stage_valid_next = 1'b0;
        end
        else
        begin
            stage_valid_next = stage_valid_reg;
        end
    end

    always_comb
    begin
        if (stage_go && stage_last_reg)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            count_reg       <= '0;
            win_start_reg   <= '0;
            best_reg        <= '0;
            ovf_reg         <= 1'b0;
            seen_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            count_reg       <= count_next;
            win_start_reg   <= win_start_next;
            best_reg        <= best_next;
            ovf_reg         <= ovf_next;
            seen_reg        <= seen_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers of the lookup stage, including the forwarded write.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            stage_sym_reg  <= in_sym;
            stage_last_reg <= in_ch.last_symbol;
            fwd_hit_reg    <= ram_wr_en && (stage_sym_reg == in_sym);
            fwd_pos_reg    <= cur_pos;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_go && stage_last_reg)
        begin
            out_len_reg <= len_clamped;
            out_ovf_reg <= ovf_reg || !has_room;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.longest_length = out_len_reg;
    assign out_ch.overflow       = out_ovf_reg;

endmodule

FILE: rtl/lurl_pos_ram.sv
// Simple dual-port RAM holding the last position of each symbol value.
// One write and one registered read per cycle; no dependencies.
module lurl_pos_ram #(
    parameter int ADDR_BITS = 8,
    parameter int DATA_BITS = 16
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [DATA_BITS-1:0] wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [DATA_BITS-1:0] rd_data
);

    logic [DATA_BITS-1:0] mem [2**ADDR_BITS];
    logic [DATA_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read returns the old contents when the same entry is written in the same cycle.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/lurl_checker.sv
// Port-level checker for the longest unique run length block, with its bind statement.
// Depends on lurl_pkg and on the top level longest_unique_run_length_top.
module lurl_checker #(
    parameter int POSITION_BITS = lurl_pkg::POSITION_BITS_DEFAULT
) (
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input lurl_pkg::length_t out_len,
    input logic              out_ovf
);

    localparam logic [33:0] RUN_LIMIT =
        ((34'd1 << POSITION_BITS) > 34'h1FFFF) ? 34'h1FFFF : (34'd1 << POSITION_BITS);

    // A held result keeps its payload until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_len) && $stable(out_ovf))
    else $error("result changed while stalled");

    // Every string holds at least one byte, so the run is never empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_len != '0)
    else $error("zero length result");

    // No run can be longer than the number of positions, nor than the field.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> {17'd0, out_len} <= RUN_LIMIT)
    else $error("length beyond the position range");

    // Reset leaves no result pending.
    assert property (@(posedge clk) !rst_n |-> !out_valid)
    else $error("result valid during reset");

endmodule

bind longest_unique_run_length_top lurl_checker #(
    .POSITION_BITS (POSITION_BITS)
) u_lurl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_len   (out_ch.longest_length),
    .out_ovf   (out_ch.overflow)
);

FILE: dv/tb_longest_unique_run_length_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for longest_unique_run_length_top.
// Depends on lurl_pkg, the channel interfaces in lurl_if and the block's RTL.
module tb_longest_unique_run_length_top;

    // The block runs with its default parameters, so the predictor uses the same values.
    localparam int POS_BITS = lurl_pkg::POSITION_BITS_DEFAULT;
    localparam int SYM_BITS = lurl_pkg::SYMBOL_BITS_DEFAULT;
    localparam longint unsigned POS_LIMIT = longint'(1) << POS_BITS;
    localparam lurl_pkg::symbol_t SYM_MASK = lurl_pkg::symbol_t'((1 << SYM_BITS) - 1);

    // Random stimulus stops once the feed, directed strings included, holds this many bytes.
    localparam int ITEM_TARGET = 1600;
    // The input is stopped only behind a full output register, so nothing more can
    // come out once the last expected result has been taken and this wait has run.
    localparam int DRAIN_CYCLES = 20;
    // The cycle limit covers a correct run of about 1600 bytes, each held up by
    // sender gaps and a slow receiver, plus two long hold-offs.
    localparam int unsigned CYCLE_LIMIT = 200000;
    // Length of the receiver's long hold-off, which fills the block and stalls its input.
    localparam int LONG_HOLD = 500;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        lurl_pkg::length_t length;
        logic              overflow;
    } run_result_t;

    // One input byte as it will be offered, with a typed-in expectation where the
    // answer is obvious from the string's shape.
    typedef struct {
        lurl_pkg::symbol_t sym;
        logic              last;
        logic              typed;
        run_result_t       typed_res;
    } feed_item_t;

    // Shapes of the directed strings.
    typedef enum {
        PAT_PERIOD,   // base + (i mod period)
        PAT_PALIN,    // base + distance to the nearer end: rises, then falls back
        PAT_RANDOM    // uniform random bytes
    } pattern_t;

    typedef struct {
        pattern_t          kind;
        int                str_len;
        int                period;
        lurl_pkg::symbol_t base;
        logic              typed;
        lurl_pkg::length_t exp_len;
        logic              exp_ovf;
    } dir_row_t;

    // Receiver ready patterns.
    typedef enum {
        RX_ALWAYS,
        RX_COIN,
        RX_ONE_IN_FOUR,
        RX_MOSTLY
    } rx_mode_t;

    logic clk;
    logic rst_n;

    lurl_in_if  in_ch();
    lurl_out_if out_ch();

    longest_unique_run_length_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // Predictor state: a private copy of the block's window tracking.
    logic                sym_seen [256];
    logic [POS_BITS-1:0] sym_last_pos [256];
    longint unsigned     pos_count;
    longint unsigned     win_start;
    longint unsigned     best_len;
    logic                ovf_seen;

    run_result_t expected_runs [$];
    feed_item_t  byte_feed [$];

    int error_count;
    int stall_requests;
    int stalls_served;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    task automatic clear_window();
        foreach (sym_seen[k])
        begin
            sym_seen[k] = 1'b0;
        end
        pos_count = 0;
        win_start = 0;
        best_len  = 0;
        ovf_seen  = 1'b0;
    endtask

    // Advances the window by one byte. On the final byte of a string it hands back
    // the run length and overflow flag, then clears the string state.
    task automatic track_symbol(input lurl_pkg::symbol_t raw, input logic last,
                                output logic done, output run_result_t res);
        lurl_pkg::symbol_t sym;
        longint unsigned   run_len;
        sym  = raw & SYM_MASK;
        done = 1'b0;
        res  = '0;
        if (pos_count >= POS_LIMIT)
        begin
            // Every position is in use: the byte is dropped but flagged.
            ovf_seen = 1'b1;
        end
        else
        begin
            // A repeat only moves the window when its previous copy is still inside it.
            if (sym_seen[sym] && longint'(sym_last_pos[sym]) >= win_start)
            begin
                win_start = longint'(sym_last_pos[sym]) + 1;
            end
            sym_seen[sym]     = 1'b1;
            sym_last_pos[sym] = pos_count[POS_BITS-1:0];
            run_len = pos_count - win_start + 1;
            if (run_len > best_len)
            begin
                best_len = run_len;
            end
            pos_count = pos_count + 1;
        end
        if (last)
        begin
            done = 1'b1;
            res.length   = (best_len > longint'(lurl_pkg::LENGTH_MAX)) ?
                           lurl_pkg::LENGTH_MAX : lurl_pkg::length_t'(best_len);
            res.overflow = ovf_seen;
            clear_window();
        end
    endtask

    task automatic note_failure(input string msg);
        error_count++;
        if (error_count <= REPORT_LIMIT)
        begin
            $display("ERROR at %0t: %s", $realtime, msg);
        end
    endtask

    task automatic push_byte(input lurl_pkg::symbol_t sym, input logic last,
                             input logic typed, input lurl_pkg::length_t exp_len,
                             input logic exp_ovf);
        feed_item_t item;
        item.sym                = sym;
        item.last               = last;
        item.typed              = typed && last;
        item.typed_res.length   = exp_len;
        item.typed_res.overflow = exp_ovf;
        byte_feed.push_back(item);
    endtask

    // Directed strings first. The expectation is typed in where the shape gives it
    // away; the rest are left to the predictor.
    task automatic build_directed();
        dir_row_t          rows [13];
        lurl_pkg::symbol_t sym;
        int                end_gap;
        rows = '{
            // single bytes at both extremes
            '{PAT_PERIOD, 1,     1,   8'h00, 1'b1, 17'd1,   1'b0},
            '{PAT_PERIOD, 1,     1,   8'hFF, 1'b1, 17'd1,   1'b0},
            // one byte repeated: every byte restarts the window
            '{PAT_PERIOD, 5,     1,   8'hAA, 1'b1, 17'd1,   1'b0},
            // every symbol value once, then wrapping round again, and shorter periods
            '{PAT_PERIOD, 256,   256, 8'h00, 1'b1, 17'd256, 1'b0},
            '{PAT_PERIOD, 300,   256, 8'h80, 1'b1, 17'd256, 1'b0},
            '{PAT_PERIOD, 10,    3,   8'h55, 1'b1, 17'd3,   1'b0},
            '{PAT_PERIOD, 2,     2,   8'hFE, 1'b1, 17'd2,   1'b0},
            // a repeat whose previous copy has already left the window, and random bytes
            '{PAT_PALIN,  4,     0,   8'h61, 1'b0, 17'd0,   1'b0},
            '{PAT_PALIN,  9,     0,   8'h10, 1'b0, 17'd0,   1'b0},
            '{PAT_RANDOM, 40,    0,   8'h00, 1'b0, 17'd0,   1'b0},
            // a lone byte right after longer strings, then a palindrome and a short random string
            '{PAT_PERIOD, 1,     1,   8'h42, 1'b1, 17'd1,   1'b0},
            '{PAT_PALIN,  31,    0,   8'hE0, 1'b0, 17'd0,   1'b0},
            '{PAT_RANDOM, 3,     0,   8'h00, 1'b0, 17'd0,   1'b0}
        };
        foreach (rows[r])
        begin
            for (int i = 0; i < rows[r].str_len; i++)
            begin
                case (rows[r].kind)
                    PAT_PERIOD:
                    begin
                        sym = rows[r].base + lurl_pkg::symbol_t'(i % rows[r].period);
                    end
                    PAT_PALIN:
                    begin
                        end_gap = (i < rows[r].str_len - 1 - i) ? i
                                                                : rows[r].str_len - 1 - i;
                        sym = rows[r].base + lurl_pkg::symbol_t'(end_gap);
                    end
                    default:
                    begin
                        sym = lurl_pkg::symbol_t'($urandom_range(0, 255));
                    end
                endcase
                push_byte(sym, i == rows[r].str_len - 1, rows[r].typed,
                          rows[r].exp_len, rows[r].exp_ovf);
            end
        end
    endtask

    // Random strings, mostly short ones over a small alphabet so that repeats and
    // window moves are frequent, with some long near-unique ones to reach full runs.
    task automatic build_random();
        int                pick;
        int                str_len;
        int                alpha;
        lurl_pkg::symbol_t base;
        lurl_pkg::symbol_t sym;
        while (byte_feed.size() < ITEM_TARGET)
        begin
            pick  = $urandom_range(0, 99);
            base  = lurl_pkg::symbol_t'($urandom_range(0, 255));
            alpha = $urandom_range(1, 16);
            if (pick < 5)
            begin
                str_len = 1;
            end
            else if (pick < 75)
            begin
                str_len = $urandom_range(1, 24);
            end
            else if (pick < 90)
            begin
                str_len = $urandom_range(1, 40);
            end
            else
            begin
                str_len = $urandom_range(200, 300);
            end
            for (int i = 0; i < str_len; i++)
            begin
                if (pick < 75)
                begin
                    sym = base + lurl_pkg::symbol_t'($urandom_range(0, alpha - 1));
                end
                else if (pick < 90)
                begin
                    sym = lurl_pkg::symbol_t'($urandom_range(0, 255));
                end
                else if ($urandom_range(0, 7) != 0)
                begin
                    sym = base + lurl_pkg::symbol_t'(i);
                end
                else
                begin
                    sym = lurl_pkg::symbol_t'($urandom_range(0, 255));
                end
                push_byte(sym, i == str_len - 1, 1'b0, '0, 1'b0);
            end
        end
    endtask

    // Receiver: checks every result transfer against the oldest expectation and
    // drives ready on a pattern of its own, with long hold-offs on request.
    initial
    begin : receiver
        run_result_t want;
        run_result_t got;
        rx_mode_t    mode;
        int          mode_left;
        int          hold_left;
        int          phase;
        logic        ready_next;
        mode          = RX_ALWAYS;
        mode_left     = 0;
        hold_left     = 0;
        phase         = 0;
        stalls_served = 0;
        out_ch.ready  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
            begin
                got.length   = out_ch.longest_length;
                got.overflow = out_ch.overflow;
                if (expected_runs.size() == 0)
                begin
                    note_failure($sformatf("unexpected result: length %0d overflow %0b",
                                           got.length, got.overflow));
                end
                else
                begin
                    want = expected_runs.pop_front();
                    if (got.length !== want.length || got.overflow !== want.overflow)
                    begin
                        note_failure($sformatf(
                            "expected length %0d overflow %0b, got length %0d overflow %0b",
                            want.length, want.overflow, got.length, got.overflow));
                    end
                end
            end
            phase++;
            if (hold_left > 0)
            begin
                hold_left--;
                ready_next = 1'b0;
            end
            else if (stall_requests > stalls_served)
            begin
                // Hold off while the sender keeps offering short strings.
                stalls_served++;
                hold_left  = LONG_HOLD - 1;
                ready_next = 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 128);
                end
                mode_left--;
                case (mode)
                    RX_ALWAYS:      ready_next = 1'b1;
                    RX_COIN:        ready_next = ($urandom_range(0, 1) == 1);
                    RX_ONE_IN_FOUR: ready_next = (phase % 4) == 0;
                    default:        ready_next = $urandom_range(0, 7) != 0;
                endcase
            end
            out_ch.ready <= ready_next;
        end
    end

    // Watchdog: a hung block or a lost result ends the run here.
    initial
    begin : watchdog
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles", CYCLE_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    // Main sequence: reset, build the stimulus, send it in bursts, drain, report.
    initial
    begin : sender
        feed_item_t  item;
        run_result_t res;
        logic        done;
        int          idx;
        int          random_start;
        int          random_mid;
        int          burst_left;
        int          gap_left;
        error_count       = 0;
        stall_requests    = 0;
        rst_n             = 1'b0;
        in_ch.valid       = 1'b0;
        in_ch.symbol      = '0;
        in_ch.last_symbol = 1'b0;
        foreach (sym_last_pos[k])
        begin
            sym_last_pos[k] = '0;
        end
        clear_window();

        build_directed();
        random_start = byte_feed.size();
        build_random();
        random_mid = random_start + (byte_feed.size() - random_start) / 2;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        idx        = 0;
        burst_left = $urandom_range(1, 24);
        gap_left   = 0;
        while (idx < byte_feed.size())
        begin
            @(posedge clk);
            if (in_ch.valid && in_ch.ready)
            begin
                // The byte at the head of the feed was just transferred.
                item = byte_feed[idx];
                track_symbol(item.sym, item.last, done, res);
                if (done)
                begin
                    expected_runs.push_back(item.typed ? item.typed_res : res);
                end
                idx++;
                // Ask the receiver for a long hold-off at two points of the random part.
                if (idx == random_start || idx == random_mid)
                begin
                    stall_requests++;
                end
                burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 600)
                                                             : $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
                end
            end
            else if (!in_ch.valid && gap_left > 0)
            begin
                gap_left--;
            end
            // An offered byte stays on the bus until it is taken; valid is set once per edge.
            if (idx < byte_feed.size() && gap_left == 0)
            begin
                in_ch.valid       <= 1'b1;
                in_ch.symbol      <= byte_feed[idx].sym;
                in_ch.last_symbol <= byte_feed[idx].last;
            end
            else
            begin
                in_ch.valid <= 1'b0;
            end
        end

        while (expected_runs.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_runs.size() != 0)
        begin
            note_failure($sformatf("%0d results never arrived", expected_runs.size()));
        end

        if (error_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
